@@ rtl/core/ilid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants of the indexed list store
// widths, operation and status codes, and the command broadcast to the cells
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int MODE_W      = 3;
    localparam int POS_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int CMP_W       = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // read select tree: groups of eight cells
    localparam int GRP_SIZE    = 8;
    localparam int GRP_W       = $clog2(GRP_SIZE);
    localparam int NGRP        = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NGRP_W      = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam int IN_FIELDS_W  = MODE_W + POS_W + VALUE_WIDTH;
    localparam int OUT_FIELDS_W = VALUE_WIDTH + STATUS_W + CNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef value_t [CAPACITY-1:0] entry_arr_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ     = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_INS_TAIL = 3'd2,
        MODE_INS_POS  = 3'd3,
        MODE_DELETE   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // shift command seen by every cell in the same cycle
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
        value_t           value;
    } cell_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/ilid_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_cell: one entry cell of the list chain
// holds one entry; on insert takes its left neighbor or the new value,
// on delete takes its right neighbor
// ----------------------------------------------------------------------------
module ilid_cell
(
    input  wire logic                      clk,
    input  wire logic [ilid_pkg::IDX_W-1:0] idx,
    input  wire ilid_pkg::cell_cmd_t       cmd,
    input  wire ilid_pkg::value_t          left,
    input  wire ilid_pkg::value_t          right,
    output ilid_pkg::value_t               value
);

    ilid_pkg::value_t value_reg;
    ilid_pkg::value_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (idx > cmd.pos)
            begin
                value_next = left;
            end
            else if (idx == cmd.pos)
            begin
                value_next = cmd.value;
            end
        end
        else if (cmd.del && (idx >= cmd.pos))
        begin
            value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
`default_nettype wire

@@ rtl/core/ilid_read_sel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_read_sel: registered two-level read select over the cell chain
// first level picks one cell per group of eight, second picks the group
// ----------------------------------------------------------------------------
module ilid_read_sel
(
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire ilid_pkg::entry_arr_t       entries,
    input  wire logic [ilid_pkg::IDX_W-1:0] idx,
    output ilid_pkg::value_t                data
);

    ilid_pkg::value_t                  grp_reg [ilid_pkg::NGRP];
    ilid_pkg::value_t                  grp_next [ilid_pkg::NGRP];
    logic [ilid_pkg::NGRP_W-1:0]       hi_reg;
    logic [ilid_pkg::GRP_W-1:0]        lo_idx;

    assign lo_idx = ilid_pkg::GRP_W'(idx);

    for (genvar g = 0; g < ilid_pkg::NGRP; g++)
    begin : g_grp
        ilid_pkg::value_t leaf [ilid_pkg::GRP_SIZE];
        for (genvar j = 0; j < ilid_pkg::GRP_SIZE; j++)
        begin : g_leaf
            if (g * ilid_pkg::GRP_SIZE + j < ilid_pkg::CAPACITY)
            begin : g_real
                assign leaf[j] = entries[g * ilid_pkg::GRP_SIZE + j];
            end
            else
            begin : g_pad
                assign leaf[j] = '0;
            end
        end
        assign grp_next[g] = leaf[lo_idx];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp_next;
            hi_reg  <= ilid_pkg::NGRP_W'(idx >> ilid_pkg::GRP_W);
        end
    end

    assign data = grp_reg[hi_reg];

endmodule
`default_nettype wire

@@ rtl/core/indexed_list_insert_delete_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core: ordered list store of bounded capacity
// ----------------------------------------------------------------------------
// Each transfer on the s_axis channel carries one operation: read at a
// position, insert at head, tail or position, or delete at a position.
// Every operation yields exactly one result transfer on m_axis with the
// value read, a status code and the entry count after the operation.
// The list lives in a chain of entry cells; an insert or delete shifts the
// cells at and after its position in the cycle after the input transfer.
// Insert, delete and rejected operations put a result on m_axis in the
// cycle after the input transfer; a valid read first passes through S_READ,
// which the registered two-level read select over the cells needs.
// Operations are handled one at a time; s_axis_tready is high only while no
// result is pending, so a new operation is taken only after the result transfer.
// A stalled m_axis holds the result and keeps s_axis_tready low.
// Reset empties the list (count zero) and needs no clearing pass; cell
// contents are unknown until written and are never read before that.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // mode[2:0], position[10:3], value_in[42:11], zero fill
    input  wire logic [ilid_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // read_value[31:0], status[33:32], entry_count[40:34], zero fill
    output logic [ilid_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    localparam int POS_LO = ilid_pkg::MODE_W;
    localparam int VAL_LO = ilid_pkg::MODE_W + ilid_pkg::POS_W;

    state_t                           state_reg, state_next;
    logic [ilid_pkg::CNT_W-1:0]       count_reg, count_next;
    ilid_pkg::value_t                 rv_reg, rv_next;
    ilid_pkg::status_t                st_reg, st_next;

    logic                             accept;
    logic [ilid_pkg::MODE_W-1:0]      mode;
    logic [ilid_pkg::POS_W-1:0]       position;
    ilid_pkg::value_t                 value_in;
    logic                             pos_neg;
    logic [ilid_pkg::CMP_W-1:0]       pos_cmp;
    logic [ilid_pkg::CMP_W-1:0]       cnt_cmp;
    logic                             full;
    logic                             read_go;
    ilid_pkg::cell_cmd_t              cmd;
    ilid_pkg::entry_arr_t             entries;
    ilid_pkg::value_t                 read_data;

    assign mode     = s_axis_tdata[POS_LO-1:0];
    assign position = s_axis_tdata[VAL_LO-1:POS_LO];
    assign value_in = s_axis_tdata[VAL_LO+ilid_pkg::VALUE_WIDTH-1:VAL_LO];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos_neg = position[ilid_pkg::POS_W-1];
    assign pos_cmp = ilid_pkg::CMP_W'(position);
    assign cnt_cmp = ilid_pkg::CMP_W'(count_reg);
    assign full    = (cnt_cmp >= ilid_pkg::CMP_W'(ilid_pkg::CAPACITY));

    // operation decode, only acted on in the transfer cycle
    always_comb
    begin
        read_go   = 1'b0;
        cmd.ins   = 1'b0;
        cmd.del   = 1'b0;
        cmd.pos   = ilid_pkg::IDX_W'(position);
        cmd.value = value_in;
        rv_next   = '0;
        st_next   = ilid_pkg::ST_DONE;
        case (ilid_pkg::mode_t'(mode))
            ilid_pkg::MODE_READ:
            begin
                if (pos_neg || (pos_cmp >= cnt_cmp))
                begin
                    rv_next = '1;
                    st_next = ilid_pkg::ST_RANGE;
                end
                else
                begin
                    read_go = 1'b1;
                end
            end
            ilid_pkg::MODE_INS_HEAD:
            begin
                cmd.pos = '0;
                if (full)
                begin
                    st_next = ilid_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins = 1'b1;
                end
            end
            ilid_pkg::MODE_INS_TAIL:
            begin
                cmd.pos = ilid_pkg::IDX_W'(count_reg);
                if (full)
                begin
                    st_next = ilid_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins = 1'b1;
                end
            end
            ilid_pkg::MODE_INS_POS:
            begin
                if (pos_neg || (pos_cmp > cnt_cmp))
                begin
                    st_next = ilid_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    st_next = ilid_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins = 1'b1;
                end
            end
            ilid_pkg::MODE_DELETE:
            begin
                if (pos_neg || (pos_cmp >= cnt_cmp))
                begin
                    st_next = ilid_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.del = 1'b1;
                end
            end
            default:
            begin
                st_next = ilid_pkg::ST_RANGE;
            end
        endcase
        if (!accept)
        begin
            cmd.ins = 1'b0;
            cmd.del = 1'b0;
            read_go = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.del)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = read_go ? S_READ : S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            st_reg    <= ilid_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (accept)
            begin
                st_reg <= st_next;
            end
        end
    end

    // result value register, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rv_reg <= rv_next;
        end
        else if (state_reg == S_READ)
        begin
            rv_reg <= read_data;
        end
    end

    // chain of entry cells
    for (genvar i = 0; i < ilid_pkg::CAPACITY; i++)
    begin : g_cell
        ilid_pkg::value_t left;
        ilid_pkg::value_t right;
        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_left
            assign left = entries[i-1];
        end
        if (i == ilid_pkg::CAPACITY - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_right
            assign right = entries[i+1];
        end
        ilid_cell u_cell
        (
            .clk   (clk),
            .idx   (ilid_pkg::IDX_W'(i)),
            .cmd   (cmd),
            .left  (left),
            .right (right),
            .value (entries[i])
        );
    end

    ilid_read_sel u_read_sel
    (
        .clk     (clk),
        .load    (read_go),
        .entries (entries),
        .idx     (ilid_pkg::IDX_W'(position)),
        .data    (read_data)
    );

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = ilid_pkg::OUT_TDATA_W'({count_reg, st_reg, rv_reg});

    // count never goes past capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
        else $error("entry count above capacity");

    // one operation at a time: no new transfer while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // a full report only comes from a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (st_reg == ilid_pkg::ST_FULL))
        |-> (count_reg == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY)))
        else $error("full status with room left");

    // count moves by at most one per cycle and only right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> $stable(count_reg))
        else $error("count changed without an operation");

    // a read never leaves the store changed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $stable(count_reg))
        else $error("count changed on read");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the indexed list store core
// ----------------------------------------------------------------------------
// Drives list operations on the s_axis channel and keeps a shadow copy of
// the list that predicts the read value, status and entry count of every
// operation. Each m_axis transfer is checked field by field against the
// oldest prediction. Covers edge positions, unknown modes, a full store,
// and long random runs that swing between filling and draining the list,
// under several source idle and sink stall mixes.
// ----------------------------------------------------------------------------
module tb;

    import ilid_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int SWING_ITEMS  = 190;
    localparam int SWING_COUNT  = 8;

    typedef struct {
        value_t                 rd_value;
        status_t                status;
        logic [CNT_W-1:0]       count;
    } list_outcome_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // mode, position, value_in, zero fill
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // read_value, status, entry_count, zero fill
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;

    // shadow copy of the list
    value_t                     list_mem [CAPACITY];
    int                         list_len;

    list_outcome_t              outcome_q [$];
    list_outcome_t              head_outcome;
    int                         errors;
    int                         cycle_cnt;
    int                         src_idle_pct;
    int                         sink_stall_pct;

    indexed_list_insert_delete_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // applies one operation to the shadow list and returns what the core must answer
    function automatic list_outcome_t list_apply_op(logic [MODE_W-1:0] mode,
                                                    logic [POS_W-1:0] pos, value_t val);
        list_outcome_t res;
        logic          neg;
        int            p;
        int            at;
        res.rd_value = '0;
        res.status   = ST_DONE;
        neg          = pos[POS_W-1];
        p            = int'(pos);
        at           = -1;
        case (mode)
            MODE_READ:
            begin
                if (neg || p >= list_len)
                begin
                    res.rd_value = '1;
                    res.status   = ST_RANGE;
                end
                else
                    res.rd_value = list_mem[p];
            end
            MODE_INS_HEAD:
            begin
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                    at = 0;
            end
            MODE_INS_TAIL:
            begin
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                    at = list_len;
            end
            MODE_INS_POS:
            begin
                // range check wins over the full check
                if (neg || p > list_len)
                    res.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                    at = p;
            end
            MODE_DELETE:
            begin
                if (neg || p >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default:
                res.status = ST_RANGE;
        endcase
        if (at >= 0)
        begin
            for (int i = list_len; i > at; i--)
                list_mem[i] = list_mem[i - 1];
            list_mem[at] = val;
            list_len++;
        end
        res.count = list_len[CNT_W-1:0];
        return res;
    endfunction

    // one operation transfer; tvalid stays high into the next call unless it idles
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                           input value_t val);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({val, pos, mode});
        do
            @(posedge clk);
        while (!s_axis_tready);
        outcome_q.push_back(list_apply_op(mode, pos, val));
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // mostly positions that hit the list, the rest out of range or anything
    function automatic logic [POS_W-1:0] pick_position(input bit for_insert);
        int top;
        top = for_insert ? list_len : ((list_len > 0) ? list_len - 1 : 0);
        case ($urandom_range(9))
            0:       return POS_W'($urandom_range(127, list_len + 1));
            1:       return POS_W'($urandom_range(255, 128));
            2:       return POS_W'($urandom());
            default: return POS_W'($urandom_range(top, 0));
        endcase
    endfunction

    task automatic test_directed_edges();
        send_op(MODE_READ, 8'd0, '0);
        send_op(MODE_DELETE, 8'd0, '0);
        send_op(MODE_INS_POS, 8'd0, 32'h8000_0000);
        send_op(MODE_INS_HEAD, 8'd0, 32'h7fff_ffff);
        send_op(MODE_INS_TAIL, 8'd0, 32'hffff_ffff);
        send_op(MODE_INS_POS, 8'd3, 32'h0000_0000);
        send_op(MODE_INS_POS, 8'd5, 32'h1234_5678);
        send_op(MODE_INS_POS, 8'h80, 32'h1234_5678);
        send_op(MODE_INS_POS, 8'h7f, 32'h1234_5678);
        send_op(MODE_INS_POS, 8'd2, 32'h5a5a_5a5a);
        send_op(MODE_READ, 8'd0, 32'hffff_ffff);
        send_op(MODE_READ, 8'd4, '0);
        send_op(MODE_READ, 8'd5, '0);
        send_op(MODE_READ, 8'hff, '0);
        send_op(MODE_READ, 8'h7f, '0);
        send_op(MODE_DELETE, 8'h80, '0);
        send_op(MODE_DELETE, 8'd5, '0);
        send_op(MODE_DELETE, 8'd2, '0);
        send_op(MODE_DELETE, 8'd3, '0);
        // unknown modes
        send_op(3'd5, POS_W'($urandom()), $urandom());
        send_op(3'd6, POS_W'($urandom()), $urandom());
        send_op(3'd7, POS_W'($urandom()), $urandom());
        send_op(MODE_INS_HEAD, 8'd0, '0);
        send_op(MODE_READ, 8'd0, '0);
    endtask

    task automatic test_full_store();
        logic [MODE_W-1:0] mode;
        while (list_len < CAPACITY)
        begin
            mode = MODE_W'($urandom_range(MODE_INS_POS, MODE_INS_HEAD));
            send_op(mode, POS_W'($urandom_range(list_len, 0)), pick_value());
        end
        send_op(MODE_INS_HEAD, 8'd0, pick_value());
        send_op(MODE_INS_TAIL, 8'd0, pick_value());
        send_op(MODE_INS_POS, 8'd10, pick_value());
        send_op(MODE_INS_POS, 8'd64, pick_value());
        send_op(MODE_INS_POS, 8'h80, pick_value());
        send_op(MODE_READ, 8'd63, '0);
        send_op(MODE_READ, 8'd64, '0);
        send_op(MODE_DELETE, 8'd63, '0);
        send_op(MODE_INS_POS, 8'd63, pick_value());
    endtask

    // swings between insert heavy and delete heavy mixes to reach empty and full
    task automatic test_random_ops();
        logic [MODE_W-1:0] mode;
        int                roll;
        bit                filling;
        for (int s = 0; s < SWING_COUNT; s++)
        begin
            case (s / 2)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 58;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 58;
                end
                default:
                begin
                    src_idle_pct   = 7;
                    sink_stall_pct = 7;
                end
            endcase
            filling = (s % 2 == 0);
            for (int n = 0; n < SWING_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    mode = MODE_W'($urandom_range(7, 5));
                else if (roll < 24)
                    mode = MODE_READ;
                else if (filling ? (roll < 36) : (roll < 76))
                    mode = MODE_DELETE;
                else
                    mode = MODE_W'($urandom_range(MODE_INS_POS, MODE_INS_HEAD));
                send_op(mode, pick_position(mode == MODE_INS_POS), pick_value());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                head_outcome = outcome_q.pop_front();
                if (m_axis_tdata[VALUE_WIDTH-1:0] !== head_outcome.rd_value)
                begin
                    $display("%0t: read_value mismatch, expected %h, actual %h", $time,
                             head_outcome.rd_value, m_axis_tdata[VALUE_WIDTH-1:0]);
                    errors++;
                end
                if (m_axis_tdata[VALUE_WIDTH +: STATUS_W] !== head_outcome.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             head_outcome.status, m_axis_tdata[VALUE_WIDTH +: STATUS_W]);
                    errors++;
                end
                if (m_axis_tdata[VALUE_WIDTH+STATUS_W +: CNT_W] !== head_outcome.count)
                begin
                    $display("%0t: entry_count mismatch, expected %0d, actual %0d", $time,
                             head_outcome.count, m_axis_tdata[VALUE_WIDTH+STATUS_W +: CNT_W]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors         = 0;
        cycle_cnt      = 0;
        list_len       = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        src_idle_pct   = 7;
        sink_stall_pct = 7;
        test_full_store();
        test_random_ops();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
